FILE: hdl/dwrp_pkg.sv
// dwrp_pkg: payload types, status and function codes, and fixed field widths
// for the draw-without-replacement pool.
// No dependencies; used by every module of the block.
`default_nettype none

package dwrp_pkg;

  // fixed field widths
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned ENTRY_W    = 10;
  localparam int unsigned RND_W      = 31;
  localparam int unsigned PICK_W     = 10;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned WC_W       = 11;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned STEP_W     = $clog2(RND_W);

  // function codes of an input item
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_WRITE_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DRAWN      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE       = 2'd2;

  // register index of word_count (word index of paddr)
  localparam logic [CFG_ADDR_W-3:0] REG_WORD_COUNT = 1'b0;

  // bit positions inside a flag memory word
  localparam int unsigned FLAG_USABLE = 1;
  localparam int unsigned FLAG_USED   = 0;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ENTRY_W-1:0] entry_index;
    logic               usable_flag;
    logic               used_flag;
    logic [RND_W-1:0]   random_value;
  } in_item_t;

  typedef struct packed {
    logic [PICK_W-1:0] picked_index;
    logic [STAT_W-1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/dwrp_mod_unit.sv
// dwrp_mod_unit: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on dwrp_pkg for the dividend width.
`default_nettype none

module dwrp_mod_unit #(
  parameter int unsigned DW = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [dwrp_pkg::RND_W-1:0] dividend,
  input  wire logic [DW-1:0]              divisor,
  output logic                            done,
  output logic [DW-1:0]                   rem
);

  logic                        busy_r;
  logic                        done_r;
  logic [dwrp_pkg::STEP_W-1:0] step_r;
  logic [dwrp_pkg::RND_W-1:0]  quo_r;
  logic [DW-1:0]               rem_r;
  logic [DW-1:0]               den_r;

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic [DW-1:0] rem_nxt;

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    shifted = {rem_r, quo_r[dwrp_pkg::RND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    if (diff[DW+1]) begin
      rem_nxt = shifted[DW-1:0];
    end else begin
      rem_nxt = diff[DW-1:0];
    end
  end

  // iteration control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quo_r  <= {quo_r[dwrp_pkg::RND_W-2:0], 1'b0};
        step_r <= step_r + dwrp_pkg::STEP_W'(1);
        if (step_r == dwrp_pkg::STEP_W'(dwrp_pkg::RND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: hdl/dwrp_ctrl.sv
// dwrp_ctrl: sequencer for the pool, holding the flag memory and the pool memory.
// Depends on dwrp_pkg and instantiates dwrp_mod_unit for the draw position.
`default_nettype none

module dwrp_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire dwrp_pkg::in_item_t        in_data,
  input  wire logic [dwrp_pkg::WC_W-1:0] word_count,
  input  wire logic                      cfg_wr,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output dwrp_pkg::out_item_t            res_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DIV_GO, ST_DIV_WAIT,
    ST_READ, ST_PICK, ST_MARK, ST_SHIFT, ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    MODE_FREE, MODE_ALL, MODE_USABLE
  } mode_t;

  // memories
  logic [1:0]       flag_mem [TABLE_DEPTH];
  logic [IDX_W-1:0] pool_mem [TABLE_DEPTH];

  state_t              state_r;
  mode_t               mode_r;
  logic [IDX_W-1:0]    clr_idx_r;
  logic                stale_r;
  logic [CNT_W-1:0]    pool_cnt_r;
  logic [CNT_W-1:0]    n_r;
  logic [dwrp_pkg::RND_W-1:0] rnd_r;
  logic [CNT_W-1:0]    idx_r;
  logic                pv_r;
  logic [IDX_W-1:0]    pa_r;
  logic [CNT_W-1:0]    pos_r;
  logic [IDX_W-1:0]    pick_r;
  dwrp_pkg::out_item_t res_r;

  logic             flag_we;
  logic [IDX_W-1:0] flag_waddr;
  logic [1:0]       flag_wdata;
  logic [IDX_W-1:0] flag_raddr;
  logic [1:0]       flag_q;
  logic             pool_we;
  logic [IDX_W-1:0] pool_waddr;
  logic [IDX_W-1:0] pool_wdata;
  logic [IDX_W-1:0] pool_raddr;
  logic [IDX_W-1:0] pool_q;

  logic             in_acc;
  logic             wr_in_range;
  logic [31:0]      wc_ext;
  logic [31:0]      present;
  logic [CNT_W-1:0] walk_limit;
  logic             walk_issue;
  logic             walk_end;
  logic             scan_take;
  logic             div_start;
  logic             div_done;
  logic [CNT_W-1:0] div_rem;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res_data  = res_r;
  assign in_acc    = in_valid && in_ready;

  // entries present: word_count clipped to the table depth
  assign wc_ext      = 32'(word_count);
  assign present     = (wc_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : wc_ext;
  assign wr_in_range = 32'(in_data.entry_index) < 32'(TABLE_DEPTH);

  // walk over memory entries, shared by rebuild scans and the gap shift
  assign walk_limit = (state_r == ST_SCAN) ? n_r : pool_cnt_r;
  assign walk_issue = ((state_r == ST_SCAN) || (state_r == ST_SHIFT)) && (idx_r < walk_limit);
  assign walk_end   = !walk_issue && !pv_r;

  // append decision for the entry whose flags just came back
  always_comb begin
    scan_take = 1'b0;
    if ((state_r == ST_SCAN) && pv_r) begin
      case (mode_r)
        MODE_FREE:   scan_take = flag_q[dwrp_pkg::FLAG_USABLE] && !flag_q[dwrp_pkg::FLAG_USED];
        MODE_ALL:    scan_take = 1'b1;
        MODE_USABLE: scan_take = flag_q[dwrp_pkg::FLAG_USABLE];
        default:     scan_take = 1'b0;
      endcase
    end
  end

  // flag memory port control
  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = pa_r;
    flag_wdata = '0;
    flag_raddr = idx_r[IDX_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_idx_r;
      end
      ST_IDLE: begin
        flag_we    = in_acc && (in_data.func == dwrp_pkg::FUNC_WRITE) && wr_in_range;
        flag_waddr = IDX_W'(in_data.entry_index);
        flag_wdata = {in_data.usable_flag, in_data.used_flag};
      end
      ST_SCAN: begin
        flag_we    = pv_r && (mode_r != MODE_FREE);
        flag_wdata = {flag_q[dwrp_pkg::FLAG_USABLE], 1'b0};
      end
      ST_PICK: begin
        flag_raddr = pool_q;
      end
      ST_MARK: begin
        flag_we    = 1'b1;
        flag_waddr = pick_r;
        flag_wdata = {flag_q[dwrp_pkg::FLAG_USABLE], 1'b1};
      end
      default: begin
        flag_we = 1'b0;
      end
    endcase
  end

  // pool memory port control
  always_comb begin
    pool_we    = 1'b0;
    pool_waddr = pa_r;
    pool_wdata = pool_q;
    pool_raddr = idx_r[IDX_W-1:0];
    case (state_r)
      ST_SCAN: begin
        pool_we    = scan_take;
        pool_waddr = pool_cnt_r[IDX_W-1:0];
        pool_wdata = pa_r;
      end
      ST_SHIFT: begin
        // entry read from slot i moves down to slot i-1
        pool_we    = pv_r;
        pool_waddr = pa_r - IDX_W'(1);
      end
      ST_READ: begin
        pool_raddr = pos_r[IDX_W-1:0];
      end
      default: begin
        pool_we = 1'b0;
      end
    endcase
  end

  // flag memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_q <= flag_mem[flag_raddr];
  end

  // pool memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    pool_q <= pool_mem[pool_raddr];
  end

  assign div_start = (state_r == ST_DIV_GO);

  dwrp_mod_unit #(
    .DW (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd_r),
    .divisor  (pool_cnt_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      mode_r     <= MODE_FREE;
      clr_idx_r  <= '0;
      stale_r    <= 1'b1;
      pool_cnt_r <= '0;
      pv_r       <= 1'b0;
      idx_r      <= '0;
    end else begin
      // walk address pipeline
      if (walk_issue) begin
        idx_r <= idx_r + CNT_W'(1);
        pa_r  <= idx_r[IDX_W-1:0];
        pv_r  <= 1'b1;
      end else begin
        pv_r <= 1'b0;
      end
      if (scan_take) begin
        pool_cnt_r <= pool_cnt_r + CNT_W'(1);
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.func == dwrp_pkg::FUNC_WRITE) begin
              stale_r <= 1'b1;
              res_r   <= '{picked_index: '0, status: dwrp_pkg::STAT_WRITE_DONE};
              state_r <= ST_RESP;
            end else begin
              rnd_r <= in_data.random_value;
              n_r   <= CNT_W'(present);
              if (stale_r || (pool_cnt_r == '0)) begin
                mode_r     <= stale_r ? MODE_FREE : MODE_USABLE;
                idx_r      <= '0;
                pool_cnt_r <= '0;
                state_r    <= ST_SCAN;
              end else begin
                state_r <= ST_DIV_GO;
              end
            end
          end
        end
        ST_SCAN: begin
          if (walk_end) begin
            if (mode_r == MODE_FREE) begin
              stale_r <= 1'b0;
            end
            if (pool_cnt_r != '0) begin
              state_r <= ST_DIV_GO;
            end else if (mode_r == MODE_FREE) begin
              // nothing free: take every present entry, clearing used marks
              mode_r  <= MODE_ALL;
              idx_r   <= '0;
              state_r <= ST_SCAN;
            end else begin
              res_r   <= '{picked_index: '0, status: dwrp_pkg::STAT_NONE};
              state_r <= ST_RESP;
            end
          end
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            pos_r   <= div_rem;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_PICK;
        end
        ST_PICK: begin
          pick_r  <= pool_q;
          idx_r   <= pos_r + CNT_W'(1);
          state_r <= ST_MARK;
        end
        ST_MARK: begin
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (walk_end) begin
            pool_cnt_r <= pool_cnt_r - CNT_W'(1);
            res_r      <= '{picked_index: dwrp_pkg::PICK_W'(pick_r),
                            status: dwrp_pkg::STAT_DRAWN};
            state_r    <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cfg_wr) begin
        stale_r <= 1'b1;
      end
    end
  end

  // a drawn entry always lies among the present entries
  a_pick_present: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res_r.status == dwrp_pkg::STAT_DRAWN) |-> CNT_W'(pick_r) < n_r)
    else $error("drawn entry outside present range");

  // remainder position falls inside the pool
  a_pos_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_WAIT) && (div_rem < pool_cnt_r))
    else $error("draw position outside pool");

  // closing the gap removes exactly one pool entry
  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) && walk_end |=> pool_cnt_r == $past(pool_cnt_r) - CNT_W'(1))
    else $error("pool count not decremented after draw");

  // a write transfer leaves the pool stale
  a_write_stale: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.func == dwrp_pkg::FUNC_WRITE) |=> stale_r)
    else $error("pool not marked stale after write");

endmodule

`default_nettype wire

FILE: hdl/draw_without_replacement_pool.sv
// Draw-without-replacement pool, top level: register port, output register and
// the pool sequencer. After reset the flag memory is cleared entry by entry,
// with in_ready low meanwhile. A draw shifts the pool entries above the drawn
// position down by one to close the gap, after a rebuild scan of the present
// entries when the pool is stale or empty (two scans when no entry is free);
// the 31-step remainder unit and the single read and write port of each memory
// set how long a draw takes.
`default_nettype none

module draw_without_replacement_pool #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input item channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire dwrp_pkg::in_item_t              in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output dwrp_pkg::out_item_t                  out_data,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dwrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [dwrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dwrp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  logic [dwrp_pkg::WC_W-1:0] word_count_r;
  logic                      out_valid_r;
  dwrp_pkg::out_item_t       out_data_r;

  logic                cfg_hit;
  logic                cfg_wr;
  logic                res_valid;
  logic                res_ready;
  dwrp_pkg::out_item_t res_data;

  // register port decode
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[dwrp_pkg::CFG_ADDR_W-1:2] == dwrp_pkg::REG_WORD_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? dwrp_pkg::CFG_DATA_W'(word_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= '0;
    end else if (cfg_wr) begin
      word_count_r <= pwdata[dwrp_pkg::WC_W-1:0];
    end
  end

  dwrp_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .word_count (word_count_r),
    .cfg_wr     (cfg_wr),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // output register: holds a result until its transfer
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_data_r <= res_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: dv/draw_without_replacement_pool_test.sv
// draw_without_replacement_pool_test: drives flag writes, draws and word count
// writes into the pool and checks every result against a predictor of the deck.
// Depends on dwrp_pkg and draw_without_replacement_pool.
module draw_without_replacement_pool_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dwrp_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned RAND_PHASES = 14;
  localparam int unsigned PHASE_ITEMS = 37;
  localparam int unsigned IDLE_PCT = 24;
  localparam logic [CFG_ADDR_W-3:0] REG_SPARE = 1'b1;
  localparam logic [RND_W-1:0] RND_MAX = '1;

  // predictor of the deck of drawable entries and queue of expected results
  class draw_tracker;
    bit can_draw [DEPTH];
    bit drawn [DEPTH];
    logic [ENTRY_W-1:0] deck [DEPTH];
    int unsigned deck_len;
    bit deck_dirty;
    logic [WC_W-1:0] wc_reg;
    out_item_t pending_picks [$];
    int unsigned mismatches;

    function new();
      deck_len = 0;
      deck_dirty = 1'b1;
      wc_reg = '0;
      mismatches = 0;
    endfunction

    function int unsigned waiting();
      return pending_picks.size();
    endfunction

    function int unsigned live_entries();
      return (wc_reg > DEPTH) ? DEPTH : int'(wc_reg);
    endfunction

    // rebuild the deck in index order, either free entries or every present one
    function void refill_deck(input int unsigned n, input bit free_only);
      deck_len = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (!free_only || (can_draw[i] && !drawn[i])) begin
          deck[deck_len] = ENTRY_W'(i);
          deck_len++;
        end
      end
    endfunction

    function void forget_draws(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) drawn[i] = 1'b0;
    endfunction

    function void set_register(input logic [CFG_ADDR_W-3:0] index,
                               input logic [CFG_DATA_W-1:0] value);
      if (index == REG_WORD_COUNT) begin
        wc_reg = value[WC_W-1:0];
        deck_dirty = 1'b1;
      end
    endfunction

    // work out the result of one accepted transfer
    function void note_item(input in_item_t item);
      out_item_t want;
      int unsigned n;
      int unsigned pos;
      logic [ENTRY_W-1:0] pick;
      n = live_entries();
      want = '0;
      if (item.func == FUNC_WRITE) begin
        can_draw[item.entry_index] = item.usable_flag;
        drawn[item.entry_index] = item.used_flag;
        deck_dirty = 1'b1;
        want.status = STAT_WRITE_DONE;
      end else begin
        if (deck_dirty) begin
          refill_deck(n, 1'b1);
          if (deck_len == 0) begin
            forget_draws(n);
            refill_deck(n, 1'b0);
          end
          deck_dirty = 1'b0;
        end
        // deck used up: start a new round with the usable entries
        if (deck_len == 0) begin
          forget_draws(n);
          refill_deck(n, 1'b1);
        end
        if (deck_len == 0) begin
          want.status = STAT_NONE;
        end else begin
          pos = int'(item.random_value) % deck_len;
          pick = deck[pos];
          drawn[pick] = 1'b1;
          for (int unsigned i = pos; i + 1 < deck_len; i++) deck[i] = deck[i + 1];
          deck_len--;
          want.picked_index = pick;
          want.status = STAT_DRAWN;
        end
      end
      pending_picks.push_back(want);
    endfunction

    function void check_pick(input out_item_t got);
      out_item_t want;
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: picked_index %0d status %0d",
                   got.picked_index, got.status);
        return;
      end
      want = pending_picks.pop_front();
      if (got.picked_index !== want.picked_index || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: picked_index exp %0d got %0d, status exp %0d got %0d",
                   want.picked_index, got.picked_index, want.status, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  draw_tracker tracker;
  bit steady;
  int unsigned quiet_cycles;

  draw_without_replacement_pool #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial out_ready <= 1'b0;
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_pick(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(input logic [FUNC_W-1:0] func,
                                         input int unsigned entry,
                                         input bit usable, input bit used,
                                         input logic [RND_W-1:0] rnd);
    in_item_t item;
    item.func = func;
    item.entry_index = ENTRY_W'(entry);
    item.usable_flag = usable;
    item.used_flag = used;
    item.random_value = rnd;
    return item;
  endfunction

  // mostly draws, writes aimed at present entries, some anywhere in the table
  function automatic in_item_t random_item(input int unsigned live);
    in_item_t item;
    item.func = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_DRAW;
    if (live == 0 || $urandom_range(0, 3) == 0)
      item.entry_index = ENTRY_W'($urandom_range(0, DEPTH - 1));
    else
      item.entry_index = ENTRY_W'($urandom_range(0, live - 1));
    item.usable_flag = ($urandom_range(0, 99) < 80);
    item.used_flag = ($urandom_range(0, 99) < 30);
    if ($urandom_range(0, 3) == 0)
      item.random_value = RND_W'($urandom_range(0, 15));
    else
      item.random_value = RND_W'($urandom());
    return item;
  endfunction

  // one input transfer, with random gaps ahead of it
  task automatic push_item(input in_item_t item);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(item);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [CFG_ADDR_W-3:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_register(index, value);
  endtask

  initial begin
    int unsigned wc;
    int unsigned live;
    tracker = new();
    steady = 1'b0;
    quiet_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // no entries present: nothing to draw
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));
    push_item(make_item(FUNC_WRITE, DEPTH - 1, 1'b1, 1'b1, RND_MAX));
    push_item(make_item(FUNC_WRITE, 0, 1'b1, 1'b0, '0));

    // three entries, one unusable; draw past the end of a round
    settle();
    write_reg(REG_WORD_COUNT, 3);
    push_item(make_item(FUNC_WRITE, 1, 1'b0, 1'b0, '0));
    push_item(make_item(FUNC_WRITE, 2, 1'b1, 1'b0, '0));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, RND_MAX));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, 5));
    // every usable entry used: rebuild falls back to all present entries
    push_item(make_item(FUNC_WRITE, 0, 1'b1, 1'b1, '0));
    push_item(make_item(FUNC_WRITE, 2, 1'b1, 1'b1, '0));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, 1));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, 1));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));

    // no usable entry among the present ones
    settle();
    write_reg(REG_WORD_COUNT, 2);
    push_item(make_item(FUNC_WRITE, 0, 1'b0, 1'b0, '0));
    push_item(make_item(FUNC_WRITE, 1, 1'b0, 1'b1, '0));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, RND_MAX));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, 3));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));

    // write to an unmapped register leaves the deck alone
    settle();
    write_reg(REG_SPARE, 5);
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));

    // word count beyond the table depth, then the full table, then one entry
    settle();
    write_reg(REG_WORD_COUNT, (1 << WC_W) - 1);
    push_item(make_item(FUNC_WRITE, 1000, 1'b1, 1'b0, '0));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, RND_MAX));
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));
    settle();
    write_reg(REG_WORD_COUNT, DEPTH);
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, 12345));
    settle();
    write_reg(REG_WORD_COUNT, 1);
    push_item(make_item(FUNC_DRAW, 0, 1'b0, 1'b0, '0));

    // random phases, mostly small tables, a few at or beyond full depth
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph)
        3: begin
          wc = DEPTH;
        end
        7: begin
          wc = 1;
        end
        9: begin
          wc = $urandom_range(DEPTH + 1, (1 << WC_W) - 1);
        end
        12: begin
          wc = 0;
        end
        default: begin
          wc = $urandom_range(2, 48);
        end
      endcase
      live = (wc > DEPTH) ? DEPTH : wc;
      write_reg(REG_WORD_COUNT, wc);
      steady = (ph == 5);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) push_item(random_item(live));
    end
    steady = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
